>>> rtl/dlf_pkg.sv
// Shared types, constants and the output clamp for the 8-point Loeffler DCT.
// No dependencies; every other file in rtl/ refers to this package by scope.
package dlf_pkg;

  localparam int OUT_W    = 20;
  localparam int COEF_W   = 16;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = 3;

  // Register index, byte address = 4 * index
  typedef enum logic [IDX_W-1:0] {
    REG_COS_ONE       = 3'd0,
    REG_SIN_ONE       = 3'd1,
    REG_COS_THREE     = 3'd2,
    REG_SIN_THREE     = 3'd3,
    REG_ROOT2_COS_SIX = 3'd4,
    REG_ROOT2_SIN_SIX = 3'd5,
    REG_ROOT_TWO      = 3'd6
  } reg_idx_t;

  localparam logic [COEF_W-1:0] RST_COS_ONE       = 16'd16069;
  localparam logic [COEF_W-1:0] RST_SIN_ONE       = 16'd3196;
  localparam logic [COEF_W-1:0] RST_COS_THREE     = 16'd13623;
  localparam logic [COEF_W-1:0] RST_SIN_THREE     = 16'd9102;
  localparam logic [COEF_W-1:0] RST_ROOT2_COS_SIX = 16'd8867;
  localparam logic [COEF_W-1:0] RST_ROOT2_SIN_SIX = 16'd21407;
  localparam logic [COEF_W-1:0] RST_ROOT_TWO      = 16'd23170;

  typedef struct packed {
    logic [COEF_W-1:0] cos_one;
    logic [COEF_W-1:0] sin_one;
    logic [COEF_W-1:0] cos_three;
    logic [COEF_W-1:0] sin_three;
    logic [COEF_W-1:0] root2_cos_six;
    logic [COEF_W-1:0] root2_sin_six;
    logic [COEF_W-1:0] root_two;
  } coef_set_t;

  // load enables for the pipeline stages held inside the datapath modules
  typedef struct packed {
    logic p2;
    logic p3;
    logic p4;
    logic p5;
  } pipe_ld_t;

  localparam logic signed [63:0] OUT_MAX = 64'sd524287;
  localparam logic signed [63:0] OUT_MIN = -64'sd524288;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/dlf_regs.sv
// APB register file holding the seven rotation and scale constants.
// Depends on dlf_pkg (coef_set_t, reg_idx_t, reset values).
module dlf_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dlf_pkg::ADDR_W-1:0]    paddr,
  input  logic [dlf_pkg::DATA_W-1:0]    pwdata,
  output logic [dlf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output dlf_pkg::coef_set_t            cfg
);

  dlf_pkg::reg_idx_t idx;
  logic              wr;
  logic [dlf_pkg::COEF_W-1:0] wval;
  logic [dlf_pkg::COEF_W-1:0] rval;

  assign idx    = dlf_pkg::reg_idx_t'(paddr[dlf_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign wval   = pwdata[dlf_pkg::COEF_W-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_one       <= dlf_pkg::RST_COS_ONE;
      cfg.sin_one       <= dlf_pkg::RST_SIN_ONE;
      cfg.cos_three     <= dlf_pkg::RST_COS_THREE;
      cfg.sin_three     <= dlf_pkg::RST_SIN_THREE;
      cfg.root2_cos_six <= dlf_pkg::RST_ROOT2_COS_SIX;
      cfg.root2_sin_six <= dlf_pkg::RST_ROOT2_SIN_SIX;
      cfg.root_two      <= dlf_pkg::RST_ROOT_TWO;
    end else if (wr) begin
      unique case (idx)
        dlf_pkg::REG_COS_ONE:       cfg.cos_one       <= wval;
        dlf_pkg::REG_SIN_ONE:       cfg.sin_one       <= wval;
        dlf_pkg::REG_COS_THREE:     cfg.cos_three     <= wval;
        dlf_pkg::REG_SIN_THREE:     cfg.sin_three     <= wval;
        dlf_pkg::REG_ROOT2_COS_SIX: cfg.root2_cos_six <= wval;
        dlf_pkg::REG_ROOT2_SIN_SIX: cfg.root2_sin_six <= wval;
        dlf_pkg::REG_ROOT_TWO:      cfg.root_two      <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dlf_pkg::REG_COS_ONE:       rval = cfg.cos_one;
      dlf_pkg::REG_SIN_ONE:       rval = cfg.sin_one;
      dlf_pkg::REG_COS_THREE:     rval = cfg.cos_three;
      dlf_pkg::REG_SIN_THREE:     rval = cfg.sin_three;
      dlf_pkg::REG_ROOT2_COS_SIX: rval = cfg.root2_cos_six;
      dlf_pkg::REG_ROOT2_SIN_SIX: rval = cfg.root2_sin_six;
      dlf_pkg::REG_ROOT_TWO:      rval = cfg.root_two;
      default:                    rval = '0;
    endcase
  end

  assign prdata = {{(dlf_pkg::DATA_W-dlf_pkg::COEF_W){1'b0}}, rval};

endmodule

>>> rtl/dlf_even.sv
// Even half of the flow graph: reflectors and the sqrt2-scaled 6pi/16 rotation.
// Depends on dlf_pkg (pipe_ld_t, COEF_W); four register stages P2..P5.
module dlf_even #(
  parameter int SW = 16,
  parameter int FB = 14
) (
  input  logic                           clk,
  input  dlf_pkg::pipe_ld_t              ld,
  input  logic [dlf_pkg::COEF_W-1:0]     c6,
  input  logic [dlf_pkg::COEF_W-1:0]     s6,
  input  logic signed [SW:0]             s0,
  input  logic signed [SW:0]             s1,
  input  logic signed [SW:0]             s2,
  input  logic signed [SW:0]             s3,
  output logic signed [SW+2:0]           y0,
  output logic signed [SW+2:0]           y4,
  output logic signed [SW+19-FB:0]       y2,
  output logic signed [SW+19-FB:0]       y6
);

  localparam int E_W    = SW + 2;
  localparam int A_W    = SW + 3;
  localparam int PROD_W = E_W + dlf_pkg::COEF_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ROT_W  = SUM_W - FB;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(64'd1 << (FB - 1));

  logic signed [E_W-1:0]    e0, e1, e2, e3;
  logic signed [A_W-1:0]    a0, a1, q0, q1, z0, z1;
  logic signed [PROD_W-1:0] m2c, m3s, m3c, m2s;
  logic signed [ROT_W-1:0]  r2, r3, z2, z3;
  logic signed [SUM_W-1:0]  sum2, sum3;
  logic signed [dlf_pkg::COEF_W:0] c6s, s6s;

  assign c6s  = $signed({1'b0, c6});
  assign s6s  = $signed({1'b0, s6});
  assign sum2 = m2c + m3s + RND;
  assign sum3 = m3c - m2s + RND;

  always_ff @(posedge clk) begin
    if (ld.p2) begin
      e0 <= s0 + s3;
      e3 <= s0 - s3;
      e1 <= s1 + s2;
      e2 <= s1 - s2;
    end
    if (ld.p3) begin
      a0  <= e0 + e1;
      a1  <= e0 - e1;
      m2c <= e2 * c6s;
      m3s <= e3 * s6s;
      m3c <= e3 * c6s;
      m2s <= e2 * s6s;
    end
    if (ld.p4) begin
      q0 <= a0;
      q1 <= a1;
      r2 <= ROT_W'(sum2 >>> FB);
      r3 <= ROT_W'(sum3 >>> FB);
    end
    if (ld.p5) begin
      z0 <= q0;
      z1 <= q1;
      z2 <= r2;
      z3 <= r3;
    end
  end

  assign y0 = z0;
  assign y4 = z1;
  assign y2 = z2;
  assign y6 = z3;

endmodule

>>> rtl/dlf_odd.sv
// Odd half of the flow graph: C3/S3 and C1/S1 rotations, reflectors, sqrt2 scaling.
// Depends on dlf_pkg (pipe_ld_t, COEF_W); four register stages P2..P5.
module dlf_odd #(
  parameter int SW = 16,
  parameter int FB = 14
) (
  input  logic                           clk,
  input  dlf_pkg::pipe_ld_t              ld,
  input  dlf_pkg::coef_set_t             cfg,
  input  logic signed [SW:0]             d4,
  input  logic signed [SW:0]             d5,
  input  logic signed [SW:0]             d6,
  input  logic signed [SW:0]             d7,
  output logic signed [SW+20-FB:0]       y1,
  output logic signed [SW+20-FB:0]       y7,
  output logic signed [SW+36-2*FB:0]     y3,
  output logic signed [SW+36-2*FB:0]     y5
);

  localparam int IN_W    = SW + 1;
  localparam int PROD_W  = IN_W + dlf_pkg::COEF_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ROT_W   = SUM_W - FB;
  localparam int REF_W   = ROT_W + 1;
  localparam int OUT_W   = ROT_W + 2;
  localparam int SCP_W   = REF_W + dlf_pkg::COEF_W + 1;
  localparam int SC_W    = SCP_W - FB;
  localparam logic signed [SUM_W-1:0] RND  = SUM_W'(64'd1 << (FB - 1));
  localparam logic signed [SCP_W-1:0] RNDS = SCP_W'(64'd1 << (FB - 1));

  logic signed [dlf_pkg::COEF_W:0] c1, s1, c3, s3, rt;
  logic signed [PROD_W-1:0] m4c, m7s, m7c, m4s, m5c, m6s, m6c, m5s;
  logic signed [SUM_W-1:0]  sum4, sum7, sum5, sum6;
  logic signed [ROT_W-1:0]  a4, a5, a6, a7;
  logic signed [REF_W-1:0]  b4, b5, b6, b7;
  logic signed [OUT_W-1:0]  c4, c7;
  logic signed [SCP_W-1:0]  p5, p6, rs5, rs6;

  assign c1 = $signed({1'b0, cfg.cos_one});
  assign s1 = $signed({1'b0, cfg.sin_one});
  assign c3 = $signed({1'b0, cfg.cos_three});
  assign s3 = $signed({1'b0, cfg.sin_three});
  assign rt = $signed({1'b0, cfg.root_two});

  assign sum4 = m4c + m7s + RND;
  assign sum7 = m7c - m4s + RND;
  assign sum5 = m5c + m6s + RND;
  assign sum6 = m6c - m5s + RND;

  always_ff @(posedge clk) begin
    if (ld.p2) begin
      m4c <= d4 * c3;
      m7s <= d7 * s3;
      m7c <= d7 * c3;
      m4s <= d4 * s3;
      m5c <= d5 * c1;
      m6s <= d6 * s1;
      m6c <= d6 * c1;
      m5s <= d5 * s1;
    end
    if (ld.p3) begin
      a4 <= ROT_W'(sum4 >>> FB);
      a7 <= ROT_W'(sum7 >>> FB);
      a5 <= ROT_W'(sum5 >>> FB);
      a6 <= ROT_W'(sum6 >>> FB);
    end
    if (ld.p4) begin
      b4 <= a4 + a6;
      b6 <= a4 - a6;
      b7 <= a7 + a5;
      b5 <= a7 - a5;
    end
    if (ld.p5) begin
      c7 <= b7 + b4;
      c4 <= b7 - b4;
      p5 <= b5 * rt;
      p6 <= b6 * rt;
    end
  end

  // round the sqrt2 products on the way out; output stage registers them
  assign rs5 = (p5 + RNDS) >>> FB;
  assign rs6 = (p6 + RNDS) >>> FB;

  assign y1 = c7;
  assign y7 = c4;
  assign y3 = rs5[SC_W-1:0];
  assign y5 = rs6[SC_W-1:0];

endmodule

>>> rtl/dct8_loeffler_fixed.sv
// Top level of the fixed-point 8-point Loeffler DCT-II: pipeline control,
// input butterfly, output clamp. Depends on dlf_pkg, dlf_regs, dlf_even, dlf_odd.
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ---------------------------------
//  in        to block   in_valid / in_ready    sample_0..sample_7, SW bits signed
//  out       from block out_valid / out_ready  coef_0..coef_7, 20 bits signed
//  apb       to block   psel/penable/pready    paddr, pwdata, prdata (7 regs)
//
// Six register stages: input butterfly, even reflect + odd products, odd rounding
// + even rotation products, odd reflect + even rounding, final reflect + sqrt2
// products, then rounding/clamp into the output register. One request per cycle
// sustained as long as out_ready does not stall the output register.
// Each stage loads when it is empty or the stage after it loads, so bubbles
// collapse and a stalled output holds every stage behind it without loss.
// rst (synchronous) empties the pipeline and reloads the constants.
module dct8_loeffler_fixed #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  // sample request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_0,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_1,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_2,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_3,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_4,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_5,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_6,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_7,
  // coefficient request channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dlf_pkg::OUT_W-1:0]   coef_0,
  output logic signed [dlf_pkg::OUT_W-1:0]   coef_1,
  output logic signed [dlf_pkg::OUT_W-1:0]   coef_2,
  output logic signed [dlf_pkg::OUT_W-1:0]   coef_3,
  output logic signed [dlf_pkg::OUT_W-1:0]   coef_4,
  output logic signed [dlf_pkg::OUT_W-1:0]   coef_5,
  output logic signed [dlf_pkg::OUT_W-1:0]   coef_6,
  output logic signed [dlf_pkg::OUT_W-1:0]   coef_7,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dlf_pkg::ADDR_W-1:0]         paddr,
  input  logic [dlf_pkg::DATA_W-1:0]         pwdata,
  output logic [dlf_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int FB     = FRACTION_BITS;
  localparam int NSTG   = 6;
  localparam int EA_W   = SW + 3;            // even reflector outputs
  localparam int ER_W   = SW + 20 - FB;      // even rotation outputs
  localparam int OC_W   = SW + 21 - FB;      // odd final reflector outputs
  localparam int OS_W   = SW + 37 - 2 * FB;  // odd sqrt2-scaled outputs

  dlf_pkg::coef_set_t cfg;
  dlf_pkg::pipe_ld_t  ld;

  logic [NSTG-1:0] valid;   // stage occupancy, valid[NSTG-1] is the output register
  logic [NSTG-1:0] load;

  // stage 1 registers: mirrored sums and differences
  logic signed [SW:0] s0, s1, s2, s3, d4, d5, d6, d7;

  logic signed [EA_W-1:0] y0, y4;
  logic signed [ER_W-1:0] y2, y6;
  logic signed [OC_W-1:0] y1, y7;
  logic signed [OS_W-1:0] y3, y5;

  // load chain: a stage takes new data when empty or when its contents move on
  always_comb begin
    load[NSTG-1] = !valid[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  assign in_ready  = load[0];
  assign out_valid = valid[NSTG-1];

  assign ld.p2 = load[1];
  assign ld.p3 = load[2];
  assign ld.p4 = load[3];
  assign ld.p5 = load[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (load[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // stage 1: sums to the even half, differences to the odd half
  always_ff @(posedge clk) begin
    if (load[0]) begin
      s0 <= sample_0 + sample_7;
      s1 <= sample_1 + sample_6;
      s2 <= sample_2 + sample_5;
      s3 <= sample_3 + sample_4;
      d7 <= sample_0 - sample_7;
      d6 <= sample_1 - sample_6;
      d5 <= sample_2 - sample_5;
      d4 <= sample_3 - sample_4;
    end
  end

  dlf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dlf_even #(.SW(SW), .FB(FB)) u_even (
    .clk (clk),
    .ld  (ld),
    .c6  (cfg.root2_cos_six),
    .s6  (cfg.root2_sin_six),
    .s0  (s0),
    .s1  (s1),
    .s2  (s2),
    .s3  (s3),
    .y0  (y0),
    .y4  (y4),
    .y2  (y2),
    .y6  (y6)
  );

  dlf_odd #(.SW(SW), .FB(FB)) u_odd (
    .clk (clk),
    .ld  (ld),
    .cfg (cfg),
    .d4  (d4),
    .d5  (d5),
    .d6  (d6),
    .d7  (d7),
    .y1  (y1),
    .y7  (y7),
    .y3  (y3),
    .y5  (y5)
  );

  // output register: clamp each coefficient to the 20-bit range
  always_ff @(posedge clk) begin
    if (load[NSTG-1]) begin
      coef_0 <= dlf_pkg::sat_out(64'(y0));
      coef_1 <= dlf_pkg::sat_out(64'(y1));
      coef_2 <= dlf_pkg::sat_out(64'(y2));
      coef_3 <= dlf_pkg::sat_out(64'(y3));
      coef_4 <= dlf_pkg::sat_out(64'(y4));
      coef_5 <= dlf_pkg::sat_out(64'(y5));
      coef_6 <= dlf_pkg::sat_out(64'(y6));
      coef_7 <= dlf_pkg::sat_out(64'(y7));
    end
  end

  // an accepted request always lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid[0])
    else $error("accepted request missing from stage 1");

  // a stalled output must not drop the item waiting behind it
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    valid[NSTG-2] && out_valid && !out_ready |=> valid[NSTG-2])
    else $error("item behind stalled output was lost");

  // a delivered result with nothing behind it leaves the output empty
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !valid[NSTG-2] |=> !out_valid)
    else $error("result repeated on output");

endmodule
